>>> hdl/ampq_pkg.sv
package ampq_pkg;

  // Request kinds as they arrive on the request channel.
  typedef enum logic [1:0] {
    KIND_INSERT    = 2'd0,
    KIND_POP       = 2'd1,
    KIND_AGE_VALUE = 2'd2,
    KIND_AGE_STEP  = 2'd3
  } kind_e;

  // Status codes reported with every result.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_DUPLICATE  = 2'd2,
    STATUS_POP_EMPTY  = 2'd3
  } status_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_COMPARE = 2'd1,
    ST_EXECUTE = 2'd2,
    ST_REPORT  = 2'd3
  } state_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_COMPARE = 3'd1,
    OP_INSERT  = 3'd2,
    OP_POP     = 3'd3,
    OP_AGE     = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] key;
    logic signed [31:0] inc;
  } cell_cmd_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic signed [31:0] key;
    logic               valid;
    logic               place;
  } link_t;

  localparam logic [30:0] AGING_STEP_RESET = 31'd1456;

endpackage

>>> hdl/ampq_req_if.sv
interface ampq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value_in;
  logic [31:0]        payload_in;

  modport source (output valid, output kind, output value_in, output payload_in,
                  input ready);
  modport sink (input valid, input kind, input value_in, input payload_in,
                output ready);
endinterface

>>> hdl/ampq_rsp_if.sv
interface ampq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] max_key;
  logic [31:0]        max_payload;
  logic [6:0]         entry_total;
  logic               is_empty;
  logic [1:0]         status;

  modport source (output valid, output max_key, output max_payload,
                  output entry_total, output is_empty, output status, input ready);
  modport sink (input valid, input max_key, input max_payload,
                input entry_total, input is_empty, input status, output ready);
endinterface

>>> hdl/ampq_cell.sv
module ampq_cell #(
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ampq_pkg::cell_cmd_t     cmd_i,
  input  logic [PAYLOAD_BITS-1:0] new_payload_i,
  input  ampq_pkg::link_t         prev_i,
  input  logic [PAYLOAD_BITS-1:0] prev_payload_i,
  input  ampq_pkg::link_t         next_i,
  input  logic [PAYLOAD_BITS-1:0] next_payload_i,
  output ampq_pkg::link_t         link_o,
  output logic [PAYLOAD_BITS-1:0] payload_o,
  output logic                    eq_o
);

  logic signed [31:0]      key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic                    valid_q, valid_d;
  logic                    place_q, place_d;
  logic                    eq_q, eq_d;
  logic signed [32:0]      sum;
  logic signed [31:0]      aged;

  // Saturating add of the aging increment.
  always_comb begin
    sum = {key_q[31], key_q} + {cmd_i.inc[31], cmd_i.inc};
    if (sum[32] != sum[31]) begin
      aged = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      aged = sum[31:0];
    end
  end

  always_comb begin
    key_d   = key_q;
    pay_d   = pay_q;
    valid_d = valid_q;
    place_d = place_q;
    eq_d    = eq_q;
    case (cmd_i.op)
      ampq_pkg::OP_COMPARE: begin
        // Empty cells always count as the place for a new key.
        place_d = !valid_q || (key_q < cmd_i.key);
        eq_d    = valid_q && (key_q == cmd_i.key);
      end
      ampq_pkg::OP_INSERT: begin
        if (place_q) begin
          if (prev_i.place) begin
            key_d = prev_i.key;
            pay_d = prev_payload_i;
          end else begin
            key_d = cmd_i.key;
            pay_d = new_payload_i;
          end
          valid_d = valid_q | prev_i.valid;
        end
      end
      ampq_pkg::OP_POP: begin
        key_d   = next_i.key;
        pay_d   = next_payload_i;
        valid_d = next_i.valid;
      end
      ampq_pkg::OP_AGE: begin
        if (valid_q) begin
          key_d = aged;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      place_q <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      place_q <= place_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign link_o.key   = key_q;
  assign link_o.valid = valid_q;
  assign link_o.place = place_q;
  assign payload_o    = pay_q;
  assign eq_o         = eq_q;

endmodule

>>> hdl/aging_max_priority_queue.sv
// Aging max-priority queue. Up to CAPACITY entries, each a signed Q16.16 key
// with a payload, are held sorted largest first in a chain of identical cells.
// Cell 0 always holds the largest key. A request passes in order through the
// cycle it is accepted, a compare cycle in which every cell checks its own key
// against the new one, an update cycle in which all cells insert, shift out
// or age together, and a report cycle that loads the result register. The
// report cycle waits while an earlier result has not been taken. No new
// request is accepted until the current one has loaded its result, but one is
// accepted while a finished result still waits on the response channel. An
// insert is dropped with the duplicate status when an equal key is stored, and
// otherwise with the full status when the store is full. A pop on an empty
// store reports the pop-on-empty status and changes nothing. Aging adds the
// request value, or the aging step register for the default-step kind, to
// every key with saturation; keys that collide at a limit stay in their order.
// The user must write the aging step register through aging_step_we_i and
// aging_step_i only while the block is idle; the block does not enforce it.
// Every valid bit is cleared by reset, so there is no clearing pass.
module aging_max_priority_queue #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        aging_step_we_i,
  input  logic [30:0] aging_step_i,
  ampq_req_if.sink    req_i,
  ampq_rsp_if.source  rsp_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  ampq_pkg::state_e        state_q, state_d;
  ampq_pkg::kind_e         kind_q;
  logic signed [31:0]      value_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [30:0]             step_q;
  logic [CNT_W-1:0]        count_q, count_d;
  ampq_pkg::status_e       status_q, status_d;

  logic                    rsp_valid_q;
  logic signed [31:0]      rsp_key_q;
  logic [31:0]             rsp_payload_q;
  logic [6:0]              rsp_total_q;
  logic                    rsp_empty_q;
  ampq_pkg::status_e       rsp_status_q;

  ampq_pkg::cell_cmd_t     cmd;
  ampq_pkg::link_t         cell_link [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay  [CAPACITY];
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     valid_vec;
  ampq_pkg::link_t         head_link, tail_link;

  logic req_fire, rsp_fire, load_rsp, duplicate, full;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;
  assign load_rsp = (state_q == ampq_pkg::ST_REPORT) && (!rsp_valid_q || rsp_o.ready);
  assign duplicate = |eq_vec;
  assign full      = (count_q == CNT_W'(CAPACITY));

  // The head of the chain is never a place and always counts as valid, so
  // the first placed cell takes the new key. The tail feeds an empty entry.
  assign head_link.key   = '0;
  assign head_link.valid = 1'b1;
  assign head_link.place = 1'b0;
  assign tail_link.key   = '0;
  assign tail_link.valid = 1'b0;
  assign tail_link.place = 1'b0;

  // Sequencer: next state, the broadcast command and the status of the step.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    status_d = status_q;
    cmd.op   = ampq_pkg::OP_HOLD;
    cmd.key  = value_q;
    cmd.inc  = (kind_q == ampq_pkg::KIND_AGE_STEP) ? {1'b0, step_q} : value_q;
    case (state_q)
      ampq_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_d = ampq_pkg::ST_COMPARE;
        end
      end
      ampq_pkg::ST_COMPARE: begin
        cmd.op  = ampq_pkg::OP_COMPARE;
        state_d = ampq_pkg::ST_EXECUTE;
      end
      ampq_pkg::ST_EXECUTE: begin
        status_d = ampq_pkg::STATUS_OK;
        case (kind_q)
          ampq_pkg::KIND_INSERT: begin
            if (duplicate) begin
              status_d = ampq_pkg::STATUS_DUPLICATE;
            end else if (full) begin
              status_d = ampq_pkg::STATUS_FULL;
            end else begin
              cmd.op  = ampq_pkg::OP_INSERT;
              count_d = count_q + 1'b1;
            end
          end
          ampq_pkg::KIND_POP: begin
            if (count_q == '0) begin
              status_d = ampq_pkg::STATUS_POP_EMPTY;
            end else begin
              cmd.op  = ampq_pkg::OP_POP;
              count_d = count_q - 1'b1;
            end
          end
          default: begin
            cmd.op = ampq_pkg::OP_AGE;
          end
        endcase
        state_d = ampq_pkg::ST_REPORT;
      end
      ampq_pkg::ST_REPORT: begin
        if (load_rsp) begin
          state_d = ampq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ampq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ampq_pkg::ST_IDLE;
      count_q     <= '0;
      status_q    <= ampq_pkg::STATUS_OK;
      step_q      <= ampq_pkg::AGING_STEP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      if (aging_step_we_i) begin
        step_q <= aging_step_i;
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q    <= ampq_pkg::kind_e'(req_i.kind);
      value_q   <= req_i.value_in;
      payload_q <= PAYLOAD_BITS'(req_i.payload_in);
    end
    if (load_rsp) begin
      rsp_key_q     <= cell_link[0].valid ? cell_link[0].key : '0;
      rsp_payload_q <= cell_link[0].valid ? 32'(cell_pay[0]) : '0;
      rsp_total_q   <= 7'(count_q);
      rsp_empty_q   <= (count_q == '0);
      rsp_status_q  <= status_q;
    end
  end

  // The chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ampq_pkg::link_t         prev_link, next_link;
    logic [PAYLOAD_BITS-1:0] prev_pay, next_pay;

    if (i == 0) begin : g_head
      assign prev_link = head_link;
      assign prev_pay  = '0;
    end else begin : g_mid
      assign prev_link = cell_link[i-1];
      assign prev_pay  = cell_pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_link = tail_link;
      assign next_pay  = '0;
    end else begin : g_body
      assign next_link = cell_link[i+1];
      assign next_pay  = cell_pay[i+1];
    end

    ampq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .new_payload_i (payload_q),
      .prev_i        (prev_link),
      .prev_payload_i(prev_pay),
      .next_i        (next_link),
      .next_payload_i(next_pay),
      .link_o        (cell_link[i]),
      .payload_o     (cell_pay[i]),
      .eq_o          (eq_vec[i])
    );

    assign valid_vec[i] = cell_link[i].valid;
  end

  assign req_i.ready       = (state_q == ampq_pkg::ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.max_key     = rsp_key_q;
  assign rsp_o.max_payload = rsp_payload_q;
  assign rsp_o.entry_total = rsp_total_q;
  assign rsp_o.is_empty    = rsp_empty_q;
  assign rsp_o.status      = rsp_status_q;

`ifndef SYNTH
  // The count never runs past the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Valid cells and the count agree at all times.
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("valid cells disagree with the entry count");

  // The head cell is valid exactly when the store is not empty.
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_link[0].valid == (count_q != '0))
    else $error("head cell validity disagrees with the count");

  // An accepted request always starts with a compare cycle.
  a_req_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == ampq_pkg::ST_COMPARE)
    else $error("accepted request did not enter the compare cycle");
`endif

endmodule

>>> tb/tb_aging_max_priority_queue.sv
`timescale 1ns / 1ps

module tb_aging_max_priority_queue;

  localparam int CAPACITY      = 64;
  localparam int LIMIT_CYCLES  = 200000;
  // Enough to cover any work still in flight when a drain waits for the block to settle.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 220;

  // Idle behavior and aging step for each random phase. The third phase draws
  // its step at random.
  localparam int unsigned SEND_IDLE[4]  = '{0, 84, 0, 30};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 84, 30};
  localparam logic [30:0] PHASE_STEP[4] = '{31'h7FFFFFFF, 31'h0, 31'h0, 31'd1456};

  // What the request driver can be told to do next.
  typedef enum {ACT_REQUEST, ACT_STEP_WRITE, ACT_DRAIN, ACT_IDLE_MODE} action_e;

  // Shapes of random stretches. A growing stretch fills the store until inserts
  // are dropped, a shrinking one drains it down to pops on an empty store.
  typedef enum {EP_GROW, EP_SHRINK, EP_MIXED} episode_e;

  typedef struct {
    action_e            action;
    ampq_pkg::kind_e    kind;
    logic signed [31:0] value;
    logic [31:0]        payload;
    logic [30:0]        step;
    int unsigned        send_idle;
    int unsigned        recv_stall;
  } pending_op_t;

  // Everything the block reports for one request.
  typedef struct {
    logic signed [31:0] max_key;
    logic [31:0]        max_payload;
    logic [6:0]         entry_total;
    logic               is_empty;
    ampq_pkg::status_e  status;
  } head_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        aging_step_we_i;
  logic [30:0] aging_step_i;

  ampq_req_if req_ch ();
  ampq_rsp_if rsp_ch ();

  aging_max_priority_queue u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .aging_step_we_i (aging_step_we_i),
    .aging_step_i    (aging_step_i),
    .req_i           (req_ch),
    .rsp_o           (rsp_ch)
  );

  // Our own copy of the sorted store: slot 0 holds the largest key, and only
  // slots below sorted_count are ever read.
  logic signed [31:0] sorted_keys[CAPACITY];
  logic [31:0]        sorted_payloads[CAPACITY];
  int                 sorted_count;
  logic [30:0]        step_setting;

  pending_op_t  pending_ops[$];
  head_report_t head_reports[$];

  logic        req_taken;
  bit          draining;
  int          settle;
  int unsigned send_idle;
  int unsigned recv_stall;
  int          errors;
  int          cycles;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one request to the store copy and returns what the block must
  // report for it. Aging sums are formed at 33 bits so that an overflow of the
  // signed 32-bit range shows up as a mismatch of the top two bits.
  function automatic head_report_t apply_request(ampq_pkg::kind_e kind,
                                                 logic signed [31:0] value,
                                                 logic [31:0] payload);
    head_report_t       rep;
    bit                 dup;
    int                 pos;
    int                 i;
    logic signed [31:0] inc;
    logic [32:0]        sum;
    rep.status = ampq_pkg::STATUS_OK;
    case (kind)
      ampq_pkg::KIND_INSERT: begin
        dup = 1'b0;
        for (i = 0; i < sorted_count; i++) begin
          if (sorted_keys[i] == value) dup = 1'b1;
        end
        // A duplicate is reported even when the store is also full.
        if (dup) begin
          rep.status = ampq_pkg::STATUS_DUPLICATE;
        end else if (sorted_count >= CAPACITY) begin
          rep.status = ampq_pkg::STATUS_FULL;
        end else begin
          // The new key goes in front of the first smaller key.
          pos = sorted_count;
          for (i = sorted_count - 1; i >= 0; i--) begin
            if (sorted_keys[i] < value) pos = i;
          end
          for (i = sorted_count; i > pos; i--) begin
            sorted_keys[i]     = sorted_keys[i - 1];
            sorted_payloads[i] = sorted_payloads[i - 1];
          end
          sorted_keys[pos]     = value;
          sorted_payloads[pos] = payload;
          sorted_count++;
        end
      end
      ampq_pkg::KIND_POP: begin
        if (sorted_count == 0) begin
          rep.status = ampq_pkg::STATUS_POP_EMPTY;
        end else begin
          for (i = 0; i < sorted_count - 1; i++) begin
            sorted_keys[i]     = sorted_keys[i + 1];
            sorted_payloads[i] = sorted_payloads[i + 1];
          end
          sorted_count--;
        end
      end
      default: begin
        // Keys that saturate to the same limit keep their order, so a later
        // pop takes the one that was larger before aging.
        inc = (kind == ampq_pkg::KIND_AGE_VALUE) ? value : $signed({1'b0, step_setting});
        for (i = 0; i < sorted_count; i++) begin
          sum = {sorted_keys[i][31], sorted_keys[i]} + {inc[31], inc};
          if (sum[32] != sum[31]) begin
            sorted_keys[i] = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
          end else begin
            sorted_keys[i] = sum[31:0];
          end
        end
      end
    endcase
    rep.entry_total = 7'(sorted_count);
    rep.is_empty    = (sorted_count == 0);
    rep.max_key     = rep.is_empty ? 32'sh0 : sorted_keys[0];
    rep.max_payload = rep.is_empty ? 32'h0 : sorted_payloads[0];
    return rep;
  endfunction

  // Keys mix the extremes, a narrow band of whole numbers that makes duplicates
  // common, and the full 32-bit range.
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(4))
        0: return 32'h7FFFFFFF;
        1: return 32'h80000000;
        2: return 32'h0;
        3: return 32'hFFFFFFFF;
        default: return 32'h1;
      endcase
    end
    if (r < 40) return (32'($urandom_range(31)) - 32'd16) << 16;
    return $urandom();
  endfunction

  // Increments are mostly small, so the store does not pin at a limit, with
  // some extremes and some full-range values to force saturation.
  function automatic logic [31:0] pick_increment();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 32'($urandom_range(32'h40000)) - 32'h20000;
    if (r < 75) begin
      case ($urandom_range(3))
        0: return 32'h7FFFFFFF;
        1: return 32'h80000000;
        2: return 32'h0;
        default: return 32'hFFFFFFFF;
      endcase
    end
    return $urandom();
  endfunction

  task automatic push_request(ampq_pkg::kind_e kind, logic [31:0] value,
                              logic [31:0] payload);
    pending_op_t op;
    op.action     = ACT_REQUEST;
    op.kind       = kind;
    op.value      = value;
    op.payload    = payload;
    op.step       = '0;
    op.send_idle  = 0;
    op.recv_stall = 0;
    pending_ops   = {pending_ops, op};
  endtask

  task automatic push_control(action_e action, logic [30:0] step, int unsigned idle,
                              int unsigned stall);
    pending_op_t op;
    op.action     = action;
    op.kind       = ampq_pkg::KIND_INSERT;
    op.value      = '0;
    op.payload    = '0;
    op.step       = step;
    op.send_idle  = idle;
    op.recv_stall = stall;
    pending_ops   = {pending_ops, op};
  endtask

  // Request driver. A request stays on the channel until it is taken; then the
  // next pending operation is started at the falling edge. A drain holds the
  // channel idle until every expected report has come back and the block has
  // had time to settle, which is the only time the aging step is written.
  always @(negedge clk_i) begin : request_driver
    pending_op_t        op;
    logic               n_valid;
    logic [1:0]         n_kind;
    logic signed [31:0] n_value;
    logic [31:0]        n_payload;
    logic               n_we;
    logic [30:0]        n_step;
    bit                 stop;
    n_valid   = req_ch.valid;
    n_kind    = req_ch.kind;
    n_value   = req_ch.value_in;
    n_payload = req_ch.payload_in;
    n_we      = 1'b0;
    n_step    = aging_step_i;
    if (rst_ni && !(req_ch.valid && !req_taken)) begin
      n_valid = 1'b0;
      if (draining) begin
        if (head_reports.size() != 0) begin
          settle = 0;
        end else begin
          settle++;
          if (settle >= SETTLE_CYCLES) draining = 1'b0;
        end
      end else begin
        stop = 1'b0;
        while (!stop && pending_ops.size() != 0) begin
          op = pending_ops[0];
          case (op.action)
            ACT_IDLE_MODE: begin
              send_idle  = op.send_idle;
              recv_stall = op.recv_stall;
              void'(pending_ops.pop_front());
            end
            ACT_DRAIN: begin
              draining = 1'b1;
              settle   = 0;
              stop     = 1'b1;
              void'(pending_ops.pop_front());
            end
            ACT_STEP_WRITE: begin
              n_we   = 1'b1;
              n_step = op.step;
              stop   = 1'b1;
              void'(pending_ops.pop_front());
            end
            default: begin
              stop = 1'b1;
              if ($urandom_range(99) >= send_idle) begin
                n_valid   = 1'b1;
                n_kind    = op.kind;
                n_value   = op.value;
                n_payload = op.payload;
                void'(pending_ops.pop_front());
              end
            end
          endcase
        end
      end
    end
    req_ch.valid      <= n_valid;
    req_ch.kind       <= n_kind;
    req_ch.value_in   <= n_value;
    req_ch.payload_in <= n_payload;
    aging_step_we_i   <= n_we;
    aging_step_i      <= n_step;
  end

  always @(negedge clk_i) begin : result_ready
    rsp_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall);
  end

  // Monitor. At each rising edge a taken request updates the store copy and
  // queues its report; a taken result is checked against the oldest report.
  always @(posedge clk_i) begin : monitor
    head_report_t want;
    cycles++;
    if (rst_ni) begin
      if (aging_step_we_i) step_setting = aging_step_i;
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken) begin
        head_reports = {head_reports,
                        apply_request(ampq_pkg::kind_e'(req_ch.kind), req_ch.value_in,
                                      req_ch.payload_in)};
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (head_reports.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting: expected none, got key %h count %0d",
                   $time, rsp_ch.max_key, rsp_ch.entry_total);
        end else begin
          want = head_reports.pop_front();
          if (rsp_ch.max_key !== want.max_key) begin
            errors++;
            $display("%0t: max_key expected %h, got %h", $time, want.max_key, rsp_ch.max_key);
          end
          if (rsp_ch.max_payload !== want.max_payload) begin
            errors++;
            $display("%0t: max_payload expected %h, got %h", $time, want.max_payload,
                     rsp_ch.max_payload);
          end
          if (rsp_ch.entry_total !== want.entry_total) begin
            errors++;
            $display("%0t: entry_total expected %0d, got %0d", $time, want.entry_total,
                     rsp_ch.entry_total);
          end
          if (rsp_ch.is_empty !== want.is_empty) begin
            errors++;
            $display("%0t: is_empty expected %b, got %b", $time, want.is_empty,
                     rsp_ch.is_empty);
          end
          if (rsp_ch.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_ch.status);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int              ph;
    int              j;
    int              made;
    int              span;
    int unsigned     r;
    episode_e        style;
    ampq_pkg::kind_e kind;
    logic [31:0]     value;
    logic [30:0]     step;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    aging_step_we_i   = 1'b0;
    aging_step_i      = '0;
    req_ch.valid      = 1'b0;
    req_ch.kind       = '0;
    req_ch.value_in   = '0;
    req_ch.payload_in = '0;
    rsp_ch.ready      = 1'b0;
    req_taken         = 1'b0;
    draining          = 1'b0;
    settle            = 0;
    send_idle         = 0;
    recv_stall        = 0;
    errors            = 0;
    cycles            = 0;
    sorted_count      = 0;
    step_setting      = ampq_pkg::AGING_STEP_RESET;

    // Directed opening, run with the aging step still at its reset value.
    // Empty store: pop and both kinds of aging change nothing.
    push_request(ampq_pkg::KIND_POP, 32'h0, 32'h0);
    push_request(ampq_pkg::KIND_AGE_VALUE, 32'h7FFFFFFF, 32'hFFFFFFFF);
    push_request(ampq_pkg::KIND_AGE_STEP, 32'h80000000, 32'h0);
    // Extreme keys and payloads, then a duplicate of the largest key.
    push_request(ampq_pkg::KIND_INSERT, 32'h7FFFFFFF, 32'hFFFFFFFF);
    push_request(ampq_pkg::KIND_INSERT, 32'h80000000, 32'h0);
    push_request(ampq_pkg::KIND_INSERT, 32'h7FFFFFFF, 32'h12345678);
    push_request(ampq_pkg::KIND_INSERT, 32'h0, 32'hA5A5A5A5);
    // Aging by the largest increment pins two keys at the top limit; the pop
    // must remove the one that was first.
    push_request(ampq_pkg::KIND_AGE_VALUE, 32'h7FFFFFFF, 32'h0);
    push_request(ampq_pkg::KIND_POP, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push_request(ampq_pkg::KIND_INSERT, 32'h7FFFFFFF, 32'h0);
    // Two steps of the most negative increment pin both keys at the bottom.
    push_request(ampq_pkg::KIND_AGE_VALUE, 32'h80000000, 32'h0);
    push_request(ampq_pkg::KIND_AGE_VALUE, 32'h80000000, 32'h0);
    push_request(ampq_pkg::KIND_AGE_STEP, 32'h0, 32'h0);
    push_request(ampq_pkg::KIND_INSERT, 32'h1, 32'h5A5A5A5A);
    push_request(ampq_pkg::KIND_INSERT, 32'hFFFFFFFF, 32'h1);
    push_request(ampq_pkg::KIND_AGE_STEP, 32'h0, 32'h0);
    // Drain to empty and one pop past it.
    for (j = 0; j < 5; j++) push_request(ampq_pkg::KIND_POP, 32'h0, 32'h0);
    push_request(ampq_pkg::KIND_AGE_VALUE, 32'hFFFFFFFF, 32'h0);

    // Random phases, each opened by a full drain and a new aging step.
    for (ph = 0; ph < 4; ph++) begin
      step = (ph == 2) ? 31'($urandom()) : PHASE_STEP[ph];
      push_control(ACT_DRAIN, '0, 0, 0);
      push_control(ACT_STEP_WRITE, step, 0, 0);
      push_control(ACT_IDLE_MODE, '0, SEND_IDLE[ph], RECV_STALL[ph]);
      made = 0;
      while (made < PHASE_ITEMS) begin
        style = episode_e'($urandom_range(2));
        span  = (style == EP_GROW) ? $urandom_range(60, 110) : $urandom_range(20, 60);
        for (j = 0; j < span; j++) begin
          r = $urandom_range(99);
          if (style == EP_GROW) begin
            if (r < 85) kind = ampq_pkg::KIND_INSERT;
            else if (r < 90) kind = ampq_pkg::KIND_POP;
            else if (r < 95) kind = ampq_pkg::KIND_AGE_VALUE;
            else kind = ampq_pkg::KIND_AGE_STEP;
          end else if (style == EP_SHRINK) begin
            if (r < 75) kind = ampq_pkg::KIND_POP;
            else if (r < 90) kind = ampq_pkg::KIND_INSERT;
            else if (r < 95) kind = ampq_pkg::KIND_AGE_VALUE;
            else kind = ampq_pkg::KIND_AGE_STEP;
          end else begin
            if (r < 40) kind = ampq_pkg::KIND_INSERT;
            else if (r < 70) kind = ampq_pkg::KIND_POP;
            else if (r < 85) kind = ampq_pkg::KIND_AGE_VALUE;
            else kind = ampq_pkg::KIND_AGE_STEP;
          end
          // Fields a kind ignores still carry random bits.
          if (kind == ampq_pkg::KIND_INSERT) value = pick_key();
          else if (kind == ampq_pkg::KIND_AGE_VALUE) value = pick_increment();
          else value = $urandom();
          push_request(kind, value, $urandom());
        end
        made += span;
      end
    end
    push_control(ACT_DRAIN, '0, 0, 0);

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    while (cycles < LIMIT_CYCLES &&
           !(pending_ops.size() == 0 && !draining && head_reports.size() == 0)) begin
      @(posedge clk_i);
    end
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles,
               head_reports.size());
      $display("simulation failed");
    end else begin
      repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
      if (errors == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ampq_pkg.sv
hdl/ampq_req_if.sv
hdl/ampq_rsp_if.sv
hdl/ampq_cell.sv
hdl/aging_max_priority_queue.sv
tb/tb_aging_max_priority_queue.sv
